/* sv/srsw_pkg.sv */
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types, constants and helpers of the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int RESULTS_CAP  = 16;

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int N_W    = $clog2(RESULTS_CAP + 1);

  localparam int SEQ_W       = 32;
  localparam int MODE_W      = 2;
  localparam int KIND_W      = 2;
  localparam int SLOT_OUT_W  = 4;
  localparam int FLIGHT_W    = 5;
  localparam int WL_W        = 5;
  localparam int TO_W        = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [WL_W-1:0] WL_RESET = WL_W'(10);
  localparam logic [TO_W-1:0] TO_RESET = TO_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = CFG_IDX_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_OFFER = 2'd0,
    MODE_ACK   = 2'd1,
    MODE_TICK  = 2'd2
  } srsw_mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS = 2'd0,
    KIND_NEW    = 2'd1,
    KIND_RETX   = 2'd2
  } srsw_kind_e;

  // Source of the result loaded into the output register.
  typedef enum logic [1:0] {
    SEL_STATUS,
    SEL_OFFER,
    SEL_ACK,
    SEL_PEND
  } srsw_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFFER,
    ST_ACK_SCAN,
    ST_ACK_RETIRE,
    ST_ACK_DONE,
    ST_TICK_START,
    ST_TICK_SCAN,
    ST_TICK_DONE,
    ST_STATUS
  } srsw_state_e;

  typedef struct packed {
    logic      load;      // latch the input item, clear scan state
    logic      offer;     // enter a new packet at the tail
    logic      scan_inc;  // step the scan index
    logic      mark_ack;  // mark the scanned entry acknowledged
    logic      retire;    // retire the head entry
    logic      tick;      // advance time
    logic      restamp;   // restamp the scanned entry and hold it as pending
    logic      emit;      // load the output register
    srsw_sel_e sel;
    logic      last;
  } srsw_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              room;
    logic              scan_end;
    logic              match;
    logic              due;
    logic              retire_ok;
    logic              pend_v;
    logic              out_free;
  } srsw_stat_t;

  function automatic logic [SLOT_W-1:0] ring_add(input logic [SLOT_W-1:0] base,
                                                 input logic [SLOT_W-1:0] off);
    logic [SLOT_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (SLOT_W + 1)'(WINDOW_DEPTH)) begin
      sum = sum - (SLOT_W + 1)'(WINDOW_DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_OUT_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[SLOT_OUT_W-1:0];
  endfunction

  function automatic logic [FLIGHT_W-1:0] flight_field(input logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[FLIGHT_W-1:0];
  endfunction

endpackage

/* sv/srsw_if.sv */
// ----------------------------------------------------------------------------
// srsw_if
// Valid/ready channels of the sender window: events, results, configuration.
// ----------------------------------------------------------------------------
interface srsw_in_if;
  logic                          valid;
  logic                          ready;
  logic [srsw_pkg::MODE_W-1:0]   mode;
  logic [srsw_pkg::SEQ_W-1:0]    ack_seq;

  modport source (output valid, output mode, output ack_seq, input ready);
  modport sink   (input valid, input mode, input ack_seq, output ready);
endinterface

interface srsw_out_if;
  logic                            valid;
  logic                            ready;
  logic [srsw_pkg::KIND_W-1:0]     kind;
  logic [srsw_pkg::SEQ_W-1:0]      seq;
  logic [srsw_pkg::SLOT_OUT_W-1:0] slot;
  logic                            ok;
  logic [srsw_pkg::FLIGHT_W-1:0]   in_flight;
  logic                            last;

  modport source (output valid, output kind, output seq, output slot, output ok,
                  output in_flight, output last, input ready);
  modport sink   (input valid, input kind, input seq, input slot, input ok,
                  input in_flight, input last, output ready);
endinterface

interface srsw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [srsw_pkg::CFG_IDX_W-1:0]  index;
  logic [srsw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/selective_repeat_sender_window_core.sv */
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_core
// Sender window of a selective-repeat ARQ link: offers, acks and ticks in,
// transmit, retransmit and status results out.
// ----------------------------------------------------------------------------
// One event is handled at a time; a new event is taken whenever the block is
// back in idle, even while the previous result still waits in the output
// register. An acknowledgment scans the outstanding entries from the head
// until one matches or the scan ends, then retires acknowledged entries from
// the head. The timeout scan of a tick reads one ring slot per cycle; each
// retransmit result holds the scan while the output is stalled. Tick results
// are emitted one per found entry, the final one flagged last, or a single
// status result when none is found.
// Configuration writes are always accepted and must be issued while idle.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  srsw_in_if.sink    in_i,
  srsw_out_if.source out_o,
  srsw_cfg_if.sink   cfg_i
);

  srsw_pkg::srsw_cmd_t  cmd;
  srsw_pkg::srsw_stat_t stat;
  logic                 in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  srsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  srsw_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mode_i       (in_i.mode),
    .in_ack_seq_i    (in_i.ack_seq),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_kind_o      (out_o.kind),
    .out_seq_o       (out_o.seq),
    .out_slot_o      (out_o.slot),
    .out_ok_o        (out_o.ok),
    .out_in_flight_o (out_o.in_flight),
    .out_last_o      (out_o.last)
  );

endmodule

/* sv/srsw_dp.sv */
// ----------------------------------------------------------------------------
// srsw_dp
// Datapath: window ring, counters, configuration registers, output register.
// ----------------------------------------------------------------------------
module srsw_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [srsw_pkg::MODE_W-1:0]     in_mode_i,
  input  logic [srsw_pkg::SEQ_W-1:0]      in_ack_seq_i,
  input  srsw_pkg::srsw_cmd_t             cmd_i,
  output srsw_pkg::srsw_stat_t            stat_o,
  input  logic                            cfg_valid_i,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [srsw_pkg::KIND_W-1:0]     out_kind_o,
  output logic [srsw_pkg::SEQ_W-1:0]      out_seq_o,
  output logic [srsw_pkg::SLOT_OUT_W-1:0] out_slot_o,
  output logic                            out_ok_o,
  output logic [srsw_pkg::FLIGHT_W-1:0]   out_in_flight_o,
  output logic                            out_last_o
);

  logic [srsw_pkg::SEQ_W-1:0]  seq_mem   [srsw_pkg::WINDOW_DEPTH];
  logic [srsw_pkg::SEQ_W-1:0]  stamp_mem [srsw_pkg::WINDOW_DEPTH];
  logic [srsw_pkg::WINDOW_DEPTH-1:0] acked_q, acked_d;

  logic [srsw_pkg::SLOT_W-1:0] head_q, head_d;
  logic [srsw_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [srsw_pkg::SEQ_W-1:0]  next_seq_q, next_seq_d;
  logic [srsw_pkg::SEQ_W-1:0]  now_q, now_d;
  logic [srsw_pkg::CNT_W-1:0]  idx_q, idx_d;
  logic [srsw_pkg::N_W-1:0]    n_q, n_d;
  logic                        hit_q, hit_d;
  logic                        pend_v_q, pend_v_d;
  logic [srsw_pkg::WL_W-1:0]   wl_q;
  logic [srsw_pkg::TO_W-1:0]   to_q;
  logic                        out_valid_q;

  logic [srsw_pkg::SEQ_W-1:0]  ack_q;
  logic [srsw_pkg::SEQ_W-1:0]  pend_seq_q;
  logic [srsw_pkg::SLOT_W-1:0] pend_slot_q;

  logic [srsw_pkg::KIND_W-1:0]     out_kind_q, res_kind;
  logic [srsw_pkg::SEQ_W-1:0]      out_seq_q, res_seq;
  logic [srsw_pkg::SLOT_OUT_W-1:0] out_slot_q, res_slot;
  logic                            out_ok_q, res_ok;
  logic [srsw_pkg::FLIGHT_W-1:0]   out_flight_q, res_flight;
  logic                            out_last_q, res_last;

  logic [srsw_pkg::SLOT_W-1:0] scan_slot, tail_slot, head_next;
  logic [31:0]                 limit, age;
  logic                        out_free;

  assign scan_slot = srsw_pkg::ring_add(head_q, idx_q[srsw_pkg::SLOT_W-1:0]);
  assign tail_slot = srsw_pkg::ring_add(head_q, cnt_q[srsw_pkg::SLOT_W-1:0]);
  assign head_next = srsw_pkg::ring_add(head_q, srsw_pkg::SLOT_W'(1));

  // A limit above the ring depth acts as the depth.
  assign limit = (32'(wl_q) > 32'(srsw_pkg::WINDOW_DEPTH)) ?
                 32'(srsw_pkg::WINDOW_DEPTH) : 32'(wl_q);
  assign age      = now_q - stamp_mem[scan_slot];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.mode      = in_mode_i;
    stat_o.room      = 32'(cnt_q) < limit;
    stat_o.scan_end  = (idx_q == cnt_q) || (n_q == srsw_pkg::N_W'(srsw_pkg::RESULTS_CAP));
    stat_o.match     = seq_mem[scan_slot] == ack_q;
    stat_o.due       = !acked_q[scan_slot] && (age > 32'(to_q));
    stat_o.retire_ok = (cnt_q != '0) && acked_q[head_q];
    stat_o.pend_v    = pend_v_q;
    stat_o.out_free  = out_free;
  end

  always_comb begin
    head_d     = head_q;
    cnt_d      = cnt_q;
    next_seq_d = next_seq_q;
    now_d      = now_q;
    idx_d      = idx_q;
    n_d        = n_q;
    hit_d      = hit_q;
    pend_v_d   = pend_v_q;
    acked_d    = acked_q;
    if (cmd_i.load) begin
      idx_d    = '0;
      n_d      = '0;
      hit_d    = 1'b0;
      pend_v_d = 1'b0;
    end
    if (cmd_i.offer) begin
      acked_d[tail_slot] = 1'b0;
      cnt_d              = cnt_q + srsw_pkg::CNT_W'(1);
      next_seq_d         = next_seq_q + 32'd1;
    end
    if (cmd_i.scan_inc) begin
      idx_d = idx_q + srsw_pkg::CNT_W'(1);
    end
    if (cmd_i.mark_ack) begin
      acked_d[scan_slot] = 1'b1;
      hit_d              = 1'b1;
    end
    if (cmd_i.retire) begin
      acked_d[head_q] = 1'b0;
      head_d          = head_next;
      cnt_d           = cnt_q - srsw_pkg::CNT_W'(1);
    end
    if (cmd_i.tick) begin
      now_d = now_q + 32'd1;
    end
    if (cmd_i.restamp) begin
      pend_v_d = 1'b1;
      n_d      = n_q + srsw_pkg::N_W'(1);
    end
  end

  always_comb begin
    res_kind   = srsw_pkg::KIND_STATUS;
    res_seq    = '0;
    res_slot   = '0;
    res_ok     = 1'b0;
    res_flight = srsw_pkg::flight_field(cnt_q);
    res_last   = 1'b1;
    case (cmd_i.sel)
      srsw_pkg::SEL_STATUS: begin
      end
      srsw_pkg::SEL_OFFER: begin
        res_kind   = srsw_pkg::KIND_NEW;
        res_seq    = next_seq_q;
        res_slot   = srsw_pkg::slot_field(tail_slot);
        res_ok     = 1'b1;
        res_flight = srsw_pkg::flight_field(cnt_q + srsw_pkg::CNT_W'(1));
      end
      srsw_pkg::SEL_ACK: begin
        res_ok = hit_q;
      end
      srsw_pkg::SEL_PEND: begin
        res_kind = srsw_pkg::KIND_RETX;
        res_seq  = pend_seq_q;
        res_slot = srsw_pkg::slot_field(pend_slot_q);
        res_last = cmd_i.last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      next_seq_q  <= '0;
      now_q       <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      hit_q       <= 1'b0;
      pend_v_q    <= 1'b0;
      acked_q     <= '0;
      wl_q        <= srsw_pkg::WL_RESET;
      to_q        <= srsw_pkg::TO_RESET;
      out_valid_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      cnt_q      <= cnt_d;
      next_seq_q <= next_seq_d;
      now_q      <= now_d;
      idx_q      <= idx_d;
      n_q        <= n_d;
      hit_q      <= hit_d;
      pend_v_q   <= pend_v_d;
      acked_q    <= acked_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          srsw_pkg::REG_WINDOW_LIMIT:  wl_q <= cfg_data_i[srsw_pkg::WL_W-1:0];
          srsw_pkg::REG_TIMEOUT_TICKS: to_q <= cfg_data_i[srsw_pkg::TO_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ack_q <= in_ack_seq_i;
    end
    if (cmd_i.offer) begin
      seq_mem[tail_slot]   <= next_seq_q;
      stamp_mem[tail_slot] <= now_q;
    end
    if (cmd_i.restamp) begin
      stamp_mem[scan_slot] <= now_q;
      pend_seq_q           <= seq_mem[scan_slot];
      pend_slot_q          <= scan_slot;
    end
    if (cmd_i.emit) begin
      out_kind_q   <= res_kind;
      out_seq_q    <= res_seq;
      out_slot_q   <= res_slot;
      out_ok_q     <= res_ok;
      out_flight_q <= res_flight;
      out_last_q   <= res_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = out_kind_q;
  assign out_seq_o       = out_seq_q;
  assign out_slot_o      = out_slot_q;
  assign out_ok_o        = out_ok_q;
  assign out_in_flight_o = out_flight_q;
  assign out_last_o      = out_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(srsw_pkg::WINDOW_DEPTH))
    else $error("outstanding count exceeds the ring depth");

  a_offer_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.offer |-> stat_o.room)
    else $error("offer entered while the window is full");

  a_offer_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.offer |=> cnt_q == $past(cnt_q) + srsw_pkg::CNT_W'(1))
    else $error("offer did not grow the window by one");

  a_retire_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.retire |-> cnt_q != '0)
    else $error("retire issued on an empty window");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result loaded over one not yet transferred");

endmodule

/* sv/srsw_ctrl.sv */
// ----------------------------------------------------------------------------
// srsw_ctrl
// Controller: sequences offers, acknowledgment scans and timeout scans.
// ----------------------------------------------------------------------------
module srsw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  srsw_pkg::srsw_stat_t stat_i,
  output srsw_pkg::srsw_cmd_t  cmd_o
);

  srsw_pkg::srsw_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      srsw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (stat_i.mode)
            srsw_pkg::MODE_OFFER: state_d = srsw_pkg::ST_OFFER;
            srsw_pkg::MODE_ACK:   state_d = srsw_pkg::ST_ACK_SCAN;
            srsw_pkg::MODE_TICK:  state_d = srsw_pkg::ST_TICK_START;
            default:              state_d = srsw_pkg::ST_STATUS;
          endcase
        end
      end
      srsw_pkg::ST_OFFER, srsw_pkg::ST_ACK_DONE, srsw_pkg::ST_TICK_DONE,
      srsw_pkg::ST_STATUS: begin
        if (stat_i.out_free) begin
          state_d = srsw_pkg::ST_IDLE;
        end
      end
      srsw_pkg::ST_ACK_SCAN: begin
        if (stat_i.scan_end || stat_i.match) begin
          state_d = srsw_pkg::ST_ACK_RETIRE;
        end
      end
      srsw_pkg::ST_ACK_RETIRE: begin
        if (!stat_i.retire_ok) begin
          state_d = srsw_pkg::ST_ACK_DONE;
        end
      end
      srsw_pkg::ST_TICK_START: state_d = srsw_pkg::ST_TICK_SCAN;
      srsw_pkg::ST_TICK_SCAN: begin
        if (stat_i.scan_end) begin
          state_d = srsw_pkg::ST_TICK_DONE;
        end
      end
      default: state_d = srsw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = srsw_pkg::SEL_STATUS;
    cmd_o.last = 1'b1;
    case (state_q)
      srsw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      srsw_pkg::ST_OFFER: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.room) begin
            cmd_o.offer = 1'b1;
            cmd_o.sel   = srsw_pkg::SEL_OFFER;
          end
        end
      end
      srsw_pkg::ST_ACK_SCAN: begin
        if (!stat_i.scan_end) begin
          if (stat_i.match) begin
            cmd_o.mark_ack = 1'b1;
          end else begin
            cmd_o.scan_inc = 1'b1;
          end
        end
      end
      srsw_pkg::ST_ACK_RETIRE: begin
        cmd_o.retire = stat_i.retire_ok;
      end
      srsw_pkg::ST_ACK_DONE: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.sel  = srsw_pkg::SEL_ACK;
      end
      srsw_pkg::ST_TICK_START: begin
        cmd_o.tick = 1'b1;
      end
      srsw_pkg::ST_TICK_SCAN: begin
        // A found entry pushes the previous one out, so the last flag is
        // only decided once the scan has ended.
        if (!stat_i.scan_end) begin
          if (!stat_i.due) begin
            cmd_o.scan_inc = 1'b1;
          end else if (!stat_i.pend_v || stat_i.out_free) begin
            cmd_o.restamp  = 1'b1;
            cmd_o.scan_inc = 1'b1;
            cmd_o.emit     = stat_i.pend_v;
            cmd_o.sel      = srsw_pkg::SEL_PEND;
            cmd_o.last     = 1'b0;
          end
        end
      end
      srsw_pkg::ST_TICK_DONE: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.sel  = stat_i.pend_v ? srsw_pkg::SEL_PEND : srsw_pkg::SEL_STATUS;
      end
      srsw_pkg::ST_STATUS: begin
        cmd_o.emit = stat_i.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srsw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q != srsw_pkg::ST_IDLE)
    else $error("accepted item did not start any work");

  a_single_ack_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mark_ack |=> state_q == srsw_pkg::ST_ACK_RETIRE)
    else $error("acknowledgment scan continued after a match");

  a_tick_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick |=> state_q == srsw_pkg::ST_TICK_SCAN)
    else $error("time advanced without a timeout scan");

endmodule
